// ----- sv/itaf_pkg.sv -----
// Shared constants, opcodes and digit-to-ASCII helper for the integer formatter.
package itaf_pkg;

  // Request opcodes
  localparam logic [2:0] OP_CHAR = 3'd0;
  localparam logic [2:0] OP_SDEC = 3'd1;
  localparam logic [2:0] OP_UDEC = 3'd2;
  localparam logic [2:0] OP_HEXL = 3'd3;
  localparam logic [2:0] OP_HEXU = 3'd4;
  localparam logic [2:0] OP_PTR  = 3'd5;

  // Operand and digit stack sizing
  localparam int unsigned MAG_W       = 64;
  localparam int unsigned STACK_DEPTH = 16;
  localparam int unsigned STACK_AW    = $clog2(STACK_DEPTH);
  localparam int unsigned SP_W        = STACK_AW + 1;

  // Reciprocal of ten for a 32-bit dividend: q = (x * RECIP_DIV10) >> RECIP_SHIFT
  localparam logic [31:0] RECIP_DIV10 = 32'hCCCC_CCCD;
  localparam int unsigned RECIP_SHIFT = 35;

  // ASCII characters used around the digits
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_LA    = 8'h61;

  // Map a digit value to its ASCII character
  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    if (d < 4'd10) begin
      return CH_ZERO + {4'b0000, d};
    end else begin
      return (upper ? CH_UA : CH_LA) + {4'b0000, d} - 8'd10;
    end
  endfunction

endpackage

// ----- sv/itaf_if.sv -----
// Valid/ready channel interfaces for requests and output characters.
interface itaf_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [63:0] value;

  modport source (output valid, output op, output value, input ready);
  modport sink   (input valid, input op, input value, output ready);
endinterface

interface itaf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_char;
  logic       last;

  modport source (output valid, output text_char, output last, input ready);
  modport sink   (input valid, input text_char, input last, output ready);
endinterface

// ----- sv/itaf_digit_unit.sv -----
// Shared digit extractor: one decimal or hex digit off the bottom of the magnitude.
module itaf_digit_unit
  import itaf_pkg::*;
(
  input  logic [MAG_W-1:0] mag,
  input  logic             hex,
  output logic [MAG_W-1:0] quot,
  output logic [3:0]       digit
);

  logic [63:0] prod;
  logic [28:0] q10;
  logic [31:0] q10_x10;
  logic [31:0] rem10;

  // Divide the low word by ten via reciprocal multiply
  assign prod    = mag[31:0] * RECIP_DIV10;
  assign q10     = prod[63:RECIP_SHIFT];
  assign q10_x10 = {q10, 3'b000} + {2'b00, q10, 1'b0};
  assign rem10   = mag[31:0] - q10_x10;

  // Select the hex shift or the decimal result
  always_comb begin
    if (hex) begin
      quot  = {4'b0000, mag[MAG_W-1:4]};
      digit = mag[3:0];
    end else begin
      quot  = {{(MAG_W-29){1'b0}}, q10};
      digit = rem10[3:0];
    end
  end

endmodule

// ----- sv/integer_to_ascii_formatter_top.sv -----
// Top level of the integer-to-ASCII formatter: sequencer, digit stack and output register.
//
// Usage:
//   in_ch  carries one conversion transaction (op, value). op selects character,
//          signed decimal, unsigned decimal, hex lower, hex upper or pointer mode;
//          op codes 6 and 7 are consumed and produce no characters.
//   out_ch carries one ASCII character per transaction, most significant first,
//          with last high on the final character of the conversion.
// Timing:
//   After acceptance the shared digit unit peels one digit per cycle into a
//   16-entry digit stack, then the prefix ('-' or "0x") and the digits leave
//   one per cycle from the output register while out_ch.ready stays high.
//   in_ch.ready is high only while the sequencer is idle, which includes the
//   cycles the final character still waits in the output register.
// Reset: rst_n (synchronous, active low) returns the sequencer to idle and
//   empties the output register; no clearing pass is needed.
// Stall: when out_ch.ready is low the character is held and the sequence pauses.
module integer_to_ascii_formatter_top
  import itaf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  itaf_in_if.sink    in_ch,
  itaf_out_if.source out_ch
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CONV = 3'd1;
  localparam logic [2:0] S_PRE  = 3'd2;
  localparam logic [2:0] S_DIG  = 3'd3;
  localparam logic [2:0] S_CHR  = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [MAG_W-1:0] mag_r, mag_nxt;
  logic             hex_r, hex_nxt;
  logic             upper_r, upper_nxt;
  logic             ptr_r, ptr_nxt;
  logic [1:0]       pre_cnt_r, pre_cnt_nxt;
  logic [SP_W-1:0]  sp_r, sp_nxt;
  logic [3:0]       stack_r [STACK_DEPTH];
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_char_r, out_char_nxt;
  logic             out_last_r, out_last_nxt;

  logic             in_fire;
  logic             out_free;
  logic             push;
  logic [MAG_W-1:0] du_quot;
  logic [3:0]       du_digit;
  logic [SP_W-1:0]  sp_dec;
  logic [31:0]      word;

  assign in_ch.ready      = (state_r == S_IDLE);
  assign in_fire          = in_ch.valid && in_ch.ready;
  assign out_free         = !out_valid_r || out_ch.ready;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.text_char = out_char_r;
  assign out_ch.last      = out_last_r;
  assign sp_dec           = sp_r - SP_W'(1);
  assign word             = in_ch.value[31:0];
  assign push             = (state_r == S_CONV);

  // Shared digit unit
  itaf_digit_unit u_digit (
    .mag   (mag_r),
    .hex   (hex_r),
    .quot  (du_quot),
    .digit (du_digit)
  );

  // Sequencer and output register next state
  always_comb begin
    state_nxt     = state_r;
    mag_nxt       = mag_r;
    hex_nxt       = hex_r;
    upper_nxt     = upper_r;
    ptr_nxt       = ptr_r;
    pre_cnt_nxt   = pre_cnt_r;
    sp_nxt        = sp_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          sp_nxt      = '0;
          hex_nxt     = (in_ch.op == OP_HEXL) || (in_ch.op == OP_HEXU) ||
                        (in_ch.op == OP_PTR);
          upper_nxt   = (in_ch.op == OP_HEXU);
          ptr_nxt     = (in_ch.op == OP_PTR);
          pre_cnt_nxt = 2'd0;
          mag_nxt     = {32'b0, word};
          case (in_ch.op)
            OP_CHAR: begin
              mag_nxt   = in_ch.value;
              state_nxt = S_CHR;
            end
            OP_SDEC: begin
              if (word[31]) begin
                mag_nxt     = {32'b0, (~word) + 32'd1};
                pre_cnt_nxt = 2'd1;
              end
              state_nxt = S_CONV;
            end
            OP_UDEC, OP_HEXL, OP_HEXU: begin
              state_nxt = S_CONV;
            end
            OP_PTR: begin
              mag_nxt     = in_ch.value;
              pre_cnt_nxt = 2'd2;
              state_nxt   = S_CONV;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_CONV: begin
        // Push one digit per cycle until the quotient runs out
        sp_nxt  = sp_r + SP_W'(1);
        mag_nxt = du_quot;
        if (du_quot == '0) begin
          state_nxt = (pre_cnt_r != 2'd0) ? S_PRE : S_DIG;
        end
      end
      S_PRE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b0;
          if (ptr_r) begin
            out_char_nxt = (pre_cnt_r == 2'd2) ? CH_ZERO : CH_X;
          end else begin
            out_char_nxt = CH_MINUS;
          end
          pre_cnt_nxt = pre_cnt_r - 2'd1;
          if (pre_cnt_r == 2'd1) begin
            state_nxt = S_DIG;
          end
        end
      end
      S_DIG: begin
        // Pop digits most significant first
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = digit_char(stack_r[sp_dec[STACK_AW-1:0]], upper_r);
          out_last_nxt  = (sp_r == SP_W'(1));
          sp_nxt        = sp_dec;
          if (sp_r == SP_W'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_CHR: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = mag_r[7:0];
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sp_r        <= '0;
      pre_cnt_r   <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sp_r        <= sp_nxt;
      pre_cnt_r   <= pre_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    mag_r      <= mag_nxt;
    hex_r      <= hex_nxt;
    upper_r    <= upper_nxt;
    ptr_r      <= ptr_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  // Digit stack write
  always_ff @(posedge clk) begin
    if (push) begin
      stack_r[sp_r[STACK_AW-1:0]] <= du_digit;
    end
  end

  // Stack never overflows its depth
  a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= SP_W'(STACK_DEPTH))
    else $error("digit stack pointer beyond depth");

  // Emission states always have at least one digit stacked
  a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PRE || state_r == S_DIG) |-> sp_r != '0)
    else $error("emission with an empty digit stack");

  // A taken non-final character is followed at once by the next one
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ch.ready && !out_last_r) |=> out_valid_r)
    else $error("gap inside a conversion");

  // New requests are only taken while idle
  a_idle_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r != S_PRE && state_r != S_DIG) && $past(state_r == S_IDLE))
    else $error("request accepted outside idle");

endmodule
